// ----- hw/rtl/ipa_pkg.sv -----
// Interval partition assigner: shared types, codes and reset values.
// No dependencies; every other file of the block imports this package.
package ipa_pkg;

    localparam int QDEPTH = 2;
    localparam int LVL_W  = 6;

    localparam logic       REG_SHIFT  = 1'b0;
    localparam logic       REG_LEVELS = 1'b1;
    localparam logic [4:0] SHIFT_RST  = 5'd12;
    localparam logic [5:0] LEVELS_RST = 6'd21;

    typedef enum logic [1:0] {
        CLS_ORG_IN  = 2'd0,
        CLS_ORG_AFT = 2'd1,
        CLS_REP_IN  = 2'd2,
        CLS_REP_AFT = 2'd3
    } t_class;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LO,
        ST_HI,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [LVL_W-1:0] levels;
        logic [31:0]      id;
        logic [31:0]      start_t;
        logic [31:0]      end_t;
    } t_meta;

    typedef struct packed {
        logic [4:0]  level;
        logic [31:0] partition;
        t_class      cls;
        logic [31:0] id;
        logic [31:0] start_t;
        logic [31:0] end_t;
        logic        last;
    } t_piece;

endpackage

// ----- hw/rtl/ipa_front.sv -----
// Front end: truncates and shifts both timestamps, saturates the level count
// and drops records that give no pieces. Depends on ipa_pkg.
module ipa_front import ipa_pkg::*; #(
    parameter int TIME_BITS  = 32,
    parameter int MAX_LEVELS = 32
) (
    input  logic                 i_push,
    input  logic                 i_full,
    input  logic [31:0]          i_record_id,
    input  logic [31:0]          i_start_time,
    input  logic [31:0]          i_end_time,
    input  logic [4:0]           i_shift,
    input  logic [LVL_W-1:0]     i_level_count,
    output logic                 o_q_push,
    output logic [TIME_BITS-1:0] o_q_a,
    output logic [TIME_BITS-1:0] o_q_b,
    output t_meta                o_q_meta
);

    logic [63:0]          w_st64;
    logic [63:0]          w_en64;
    logic [TIME_BITS-1:0] w_st;
    logic [TIME_BITS-1:0] w_en;
    logic [TIME_BITS-1:0] w_a;
    logic [TIME_BITS-1:0] w_b;
    logic [LVL_W-1:0]     w_levels;
    logic                 w_keep;

    assign w_st64 = {32'b0, i_start_time};
    assign w_en64 = {32'b0, i_end_time};
    assign w_st   = w_st64[TIME_BITS-1:0];
    assign w_en   = w_en64[TIME_BITS-1:0];
    assign w_a    = w_st >> i_shift;
    assign w_b    = w_en >> i_shift;

    assign w_levels = (i_level_count > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS)
                                                           : i_level_count;
    assign w_keep   = (w_a <= w_b) && (w_levels != '0);

    assign o_q_push         = i_push && !i_full && w_keep;
    assign o_q_a            = w_a;
    assign o_q_b            = w_b;
    assign o_q_meta.levels  = w_levels;
    assign o_q_meta.id      = i_record_id;
    assign o_q_meta.start_t = i_start_time;
    assign o_q_meta.end_t   = i_end_time;

endmodule

// ----- hw/rtl/ipa_queue.sv -----
// Short record queue between the front end and the level climber.
// Depends on ipa_pkg for the depth and the record type.
module ipa_queue import ipa_pkg::*; #(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [TIME_BITS-1:0] i_a,
    input  logic [TIME_BITS-1:0] i_b,
    input  t_meta                i_meta,
    output logic                 o_full,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic [TIME_BITS-1:0] o_a,
    output logic [TIME_BITS-1:0] o_b,
    output t_meta                o_meta
);

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = PW + 1;

    logic [TIME_BITS-1:0] r_qa [QDEPTH];
    logic [TIME_BITS-1:0] r_qb [QDEPTH];
    t_meta                r_qm [QDEPTH];
    logic [PW-1:0]        r_wp;
    logic [PW-1:0]        r_rp;
    logic [CW-1:0]        r_cnt;
    logic                 w_wr;
    logic                 w_rd;

    assign o_full  = (r_cnt == CW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_qa[r_wp] <= i_a;
            r_qb[r_wp] <= i_b;
            r_qm[r_wp] <= i_meta;
        end
    end

    assign o_a    = r_qa[r_rp];
    assign o_b    = r_qb[r_rp];
    assign o_meta = r_qm[r_rp];

endmodule

// ----- hw/rtl/ipa_climb.sv -----
// Back end: climbs the levels of one record, classes each piece and holds
// the newest piece back until the next one or the end marks it. Uses ipa_pkg.
module ipa_climb import ipa_pkg::*; #(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  logic [TIME_BITS-1:0] i_q_a,
    input  logic [TIME_BITS-1:0] i_q_b,
    input  t_meta                i_q_meta,
    output logic                 o_q_pop,
    input  logic                 i_pop,
    output logic                 o_res_v,
    output t_piece               o_res
);

    t_state               r_state;
    t_state               n_state;
    logic [TIME_BITS:0]   r_a;
    logic [TIME_BITS:0]   n_a;
    logic [TIME_BITS-1:0] r_b;
    logic [TIME_BITS-1:0] n_b;
    logic [LVL_W-1:0]     r_lvl;
    logic [LVL_W-1:0]     n_lvl;
    logic                 r_first;
    logic                 n_first;
    logic                 r_last;
    logic                 n_last;
    t_meta                r_meta;
    t_meta                n_meta;
    logic                 r_pnd_v;
    logic                 n_pnd_v;
    t_piece               r_pnd;
    t_piece               n_pnd;
    logic                 r_out_v;
    logic                 n_out_v;
    t_piece               r_out;
    t_piece               n_out;

    logic                 w_out_free;
    logic                 w_adv;
    logic                 w_emit;
    logic [31:0]          w_part;
    t_class               w_cls;
    logic                 w_eq;
    logic                 w_below;
    logic [TIME_BITS-1:0] w_bdec;
    logic [64:0]          w_a65;
    logic [64:0]          w_b65;

    assign w_out_free = !r_out_v || i_pop;
    assign w_adv      = !r_pnd_v || w_out_free;
    assign w_eq       = (r_a == {1'b0, r_b});
    assign w_bdec     = r_b - 1'b1;
    assign w_a65      = 65'(r_a);
    assign w_b65      = 65'(r_b);

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_lvl   = r_lvl;
        n_first = r_first;
        n_last  = r_last;
        n_meta  = r_meta;
        n_pnd_v = r_pnd_v;
        n_pnd   = r_pnd;
        n_out_v = r_out_v;
        n_out   = r_out;
        o_q_pop = 1'b0;
        w_emit  = 1'b0;
        w_part  = w_a65[31:0];
        w_cls   = CLS_ORG_IN;
        w_below = 1'b0;

        if (r_out_v && i_pop) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_a     = {1'b0, i_q_a};
                    n_b     = i_q_b;
                    n_meta  = i_q_meta;
                    n_lvl   = '0;
                    n_first = 1'b0;
                    n_last  = 1'b0;
                    n_state = ST_LO;
                end
            end
            ST_LO: begin
                if (w_adv) begin
                    if ((r_lvl < r_meta.levels) && ({1'b0, r_b} >= r_a)) begin
                        if (r_a[0]) begin
                            w_emit = 1'b1;
                            w_part = w_a65[31:0];
                            if (r_first) begin
                                if (w_eq && !r_last) begin
                                    w_cls  = CLS_REP_IN;
                                    n_last = 1'b1;
                                end else begin
                                    w_cls = CLS_REP_AFT;
                                end
                            end else begin
                                w_cls   = (w_eq && !r_last) ? CLS_ORG_IN : CLS_ORG_AFT;
                                n_first = 1'b1;
                            end
                            n_a = r_a + 1'b1;
                        end
                        n_state = ST_HI;
                    end else begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_HI: begin
                if (w_adv) begin
                    if (!r_b[0]) begin
                        w_emit  = 1'b1;
                        w_part  = w_b65[31:0];
                        w_below = (r_b == '0) || ({1'b0, w_bdec} < r_a);
                        if (!r_first && w_below) begin
                            w_cls = r_last ? CLS_ORG_AFT : CLS_ORG_IN;
                        end else if (!r_last) begin
                            w_cls  = CLS_REP_IN;
                            n_last = 1'b1;
                        end else begin
                            w_cls = CLS_REP_AFT;
                        end
                    end
                    if (!r_b[0] && (r_b == '0)) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_a     = r_a >> 1;
                        n_b     = (r_b[0] ? r_b : w_bdec) >> 1;
                        n_lvl   = r_lvl + 1'b1;
                        n_state = ST_LO;
                    end
                end
            end
            ST_FLUSH: begin
                if (w_adv) begin
                    if (r_pnd_v) begin
                        n_out      = r_pnd;
                        n_out.last = 1'b1;
                        n_out_v    = 1'b1;
                        n_pnd_v    = 1'b0;
                    end
                    n_state = ST_IDLE;
                end
            end
        endcase

        if (w_emit) begin
            if (r_pnd_v) begin
                n_out   = r_pnd;
                n_out_v = 1'b1;
            end
            n_pnd_v         = 1'b1;
            n_pnd.level     = r_lvl[4:0];
            n_pnd.partition = w_part;
            n_pnd.cls       = w_cls;
            n_pnd.id        = r_meta.id;
            n_pnd.start_t   = r_meta.start_t;
            n_pnd.end_t     = r_meta.end_t;
            n_pnd.last      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pnd_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pnd_v <= n_pnd_v;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_b     <= n_b;
        r_lvl   <= n_lvl;
        r_first <= n_first;
        r_last  <= n_last;
        r_meta  <= n_meta;
        r_pnd   <= n_pnd;
        r_out   <= n_out;
    end

    assign o_res_v = r_out_v;
    assign o_res   = r_out;

endmodule

// ----- hw/rtl/interval_partition_assigner.sv -----
// Interval partition assigner, top level: configuration registers, front end,
// record queue and level climber. Depends on ipa_pkg, ipa_front, ipa_queue, ipa_climb.
// Each record (id, start, end) is mapped onto a binary partition hierarchy and
// gives up to two pieces per level climbed, delivered oldest first on a queue-style
// result port with last_piece set on the final piece of the record. Records whose
// shifted start lies beyond the shifted end, or with a level count of zero, give
// nothing. The climber loads a record in ST_IDLE, then visits each level in ST_LO
// (start bound) and ST_HI (end bound) until ST_LO finds the climb over or the end
// prefix reaches zero, and then closes the record in ST_FLUSH; the front end and a
// two-deep record queue take new records meanwhile. Result stalls hold the climber
// once a piece is held back.
module interval_partition_assigner import ipa_pkg::*; #(
    parameter int TIME_BITS  = 32,
    parameter int MAX_LEVELS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_record_id,
    input  logic [31:0] i_start_time,
    input  logic [31:0] i_end_time,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  o_level,
    output logic [31:0] o_partition,
    output logic [1:0]  o_piece_class,
    output logic [31:0] o_out_id,
    output logic [31:0] o_out_start,
    output logic [31:0] o_out_end,
    output logic        o_last_piece,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [4:0]           r_shift;
    logic [LVL_W-1:0]     r_levels;
    logic                 w_q_push;
    logic [TIME_BITS-1:0] w_f_a;
    logic [TIME_BITS-1:0] w_f_b;
    t_meta                w_f_meta;
    logic                 w_q_full;
    logic                 w_q_empty;
    logic                 w_q_pop;
    logic [TIME_BITS-1:0] w_q_a;
    logic [TIME_BITS-1:0] w_q_b;
    t_meta                w_q_meta;
    logic                 w_res_v;
    t_piece               w_res;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= SHIFT_RST;
            r_levels <= LEVELS_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_SHIFT:  r_shift  <= pwdata[4:0];
                REG_LEVELS: r_levels <= pwdata[LVL_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SHIFT:  prdata = {27'b0, r_shift};
            REG_LEVELS: prdata = {{(32-LVL_W){1'b0}}, r_levels};
        endcase
    end

    assign full = w_q_full;

    ipa_front #(
        .TIME_BITS  (TIME_BITS),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_front (
        .i_push        (push),
        .i_full        (w_q_full),
        .i_record_id   (i_record_id),
        .i_start_time  (i_start_time),
        .i_end_time    (i_end_time),
        .i_shift       (r_shift),
        .i_level_count (r_levels),
        .o_q_push      (w_q_push),
        .o_q_a         (w_f_a),
        .o_q_b         (w_f_b),
        .o_q_meta      (w_f_meta)
    );

    ipa_queue #(
        .TIME_BITS (TIME_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_a     (w_f_a),
        .i_b     (w_f_b),
        .i_meta  (w_f_meta),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .i_pop   (w_q_pop),
        .o_a     (w_q_a),
        .o_b     (w_q_b),
        .o_meta  (w_q_meta)
    );

    ipa_climb #(
        .TIME_BITS (TIME_BITS)
    ) u_climb (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_q_a     (w_q_a),
        .i_q_b     (w_q_b),
        .i_q_meta  (w_q_meta),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_res_v   (w_res_v),
        .o_res     (w_res)
    );

    assign empty         = !w_res_v;
    assign o_level       = w_res.level;
    assign o_partition   = w_res.partition;
    assign o_piece_class = w_res.cls;
    assign o_out_id      = w_res.id;
    assign o_out_start   = w_res.start_t;
    assign o_out_end     = w_res.end_t;
    assign o_last_piece  = w_res.last;

endmodule

// ----- hw/rtl/ipa_checker.sv -----
// Port-level checks for interval_partition_assigner, attached by bind.
// Depends on ipa_pkg for the piece class codes and the register codes.
module ipa_checker import ipa_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [31:0] o_partition,
    input logic [31:0] o_out_id,
    input logic [1:0]  o_piece_class,
    input logic        o_last_piece,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic        pready,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_partition) && $stable(o_out_id)
                           && $stable(o_piece_class) && $stable(o_last_piece))
        else $error("waiting result changed while stalled");

    a_org_in_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_piece_class == CLS_ORG_IN) |-> o_last_piece)
        else $error("original-in piece not marked last");

    a_shift_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && (paddr[2] == REG_SHIFT)
        |=> (paddr[2] != REG_SHIFT) || (prdata[4:0] == $past(pwdata[4:0])))
        else $error("shift register readback mismatch");

    a_levels_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && (paddr[2] == REG_LEVELS)
        |=> (paddr[2] != REG_LEVELS) || (prdata[5:0] == $past(pwdata[5:0])))
        else $error("level count register readback mismatch");

endmodule

bind interval_partition_assigner ipa_checker u_ipa_checker (.*);
